// ===== hdl/region_read_coverage_profile_top_assert.svh =====
// assertion macros for the region read coverage profile block
// depends on clk_i and rst_ni being visible in the including module
`ifndef REGION_READ_COVERAGE_PROFILE_TOP_ASSERT_SVH
`define REGION_READ_COVERAGE_PROFILE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RRCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// expression must never be true outside reset
`define RRCP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define RRCP_ASSERT(lbl, prop, msg)
`define RRCP_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== hdl/rrcp_pkg.sv =====
// shared types and constants for the region read coverage profile block
// no dependencies
package rrcp_pkg;

  // default store geometry
  localparam int unsigned RRCP_BINS        = 4096;
  localparam int unsigned RRCP_COUNT_WIDTH = 16;

  // command codes
  localparam logic [1:0] RRCP_CMD_ADD   = 2'd0;
  localparam logic [1:0] RRCP_CMD_READ  = 2'd1;
  localparam logic [1:0] RRCP_CMD_CLEAR = 2'd2;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] RRCP_REG_START = 2'd0;
  localparam logic [1:0] RRCP_REG_END   = 2'd1;
  localparam logic [1:0] RRCP_REG_EXT   = 2'd2;

  // register reset values
  localparam logic [31:0] RRCP_START_RST = 32'd0;
  localparam logic [31:0] RRCP_END_RST   = 32'd4095;
  localparam logic [15:0] RRCP_EXT_RST   = 16'd200;

  // input item
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] read_position;
    logic [11:0] bin_index;
  } rrcp_in_item_t;

  // result item
  typedef struct packed {
    logic [15:0] bin_count;
    logic        read_counted;
    logic        list_stopped;
  } rrcp_out_item_t;

  // bin store port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } rrcp_mem_ctl_t;

endpackage

// ===== hdl/rrcp_bin_store.sv =====
// bin count memory: one write port, one read port with registered data
// depends on rrcp_pkg for the port control struct and the default geometry
module rrcp_bin_store import rrcp_pkg::*; #(
  parameter int unsigned Depth     = RRCP_BINS,
  parameter int unsigned Width     = RRCP_COUNT_WIDTH,
  parameter int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  rrcp_mem_ctl_t        ctl_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/region_read_coverage_profile_top.sv =====
// Coverage pileup over one region, one item at a time. Cycles per item, from the
// accepting cycle through the output register load, run: add SPAN, CHECK, CLIP,
// RUN once per covered bin in the store, DRAIN, DONE (CHECK to DONE on a region
// miss, empty region or stopped list, CLIP to DONE past the store); read RDADDR,
// RDDATA, DONE; clear CLEAR, DONE; a stalled output holds DONE. The result waits
// in an output register while the next item is taken. Reset sweeps bins to zero.
module region_read_coverage_profile_top import rrcp_pkg::*; #(
  parameter int unsigned BINS        = RRCP_BINS,
  parameter int unsigned COUNT_WIDTH = RRCP_COUNT_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // item input
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rrcp_in_item_t  in_item_i,
  // result output
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rrcp_out_item_t out_item_o,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [AW-1:0] LastBin = AW'(BINS - 1);
  localparam logic [31:0] BinsW = 32'(BINS);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SPAN   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_CLIP   = 4'd4;
  localparam logic [3:0] S_RUN    = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_RDADDR = 4'd7;
  localparam logic [3:0] S_RDDATA = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // configuration registers
  logic [31:0] start_q, end_q;
  logic [15:0] ext_q;
  logic        cfg_wr;

  // sequencer state
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] last_q, last_d;
  logic          clr_cmd_q, clr_cmd_d;
  logic          wb_valid_q, wb_valid_d;
  logic [AW-1:0] wb_addr_q, wb_addr_d;
  logic          seen_q, seen_d;
  logic          stopped_q, stopped_d;

  // item and work registers
  logic [31:0]   pos_q, pos_d;
  logic [11:0]   idx_q, idx_d;
  logic [32:0]   sum_q, sum_d;
  logic [31:0]   lo_q, lo_d;
  logic [31:0]   hi_q, hi_d;
  logic [15:0]   res_count_q, res_count_d;
  logic          res_counted_q, res_counted_d;

  // output register
  logic           out_valid_q, out_valid_d;
  rrcp_out_item_t out_q, out_d;

  // memory side
  rrcp_mem_ctl_t        mem_ctl;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata;

  // span arithmetic
  logic        overlap;
  logic [31:0] lo_calc;
  logic [32:0] hi_min, hi_full;
  logic        accept;

  // configuration write and read-back
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RRCP_START_RST;
      end_q   <= RRCP_END_RST;
      ext_q   <= RRCP_EXT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RRCP_REG_START: start_q <= pwdata;
        RRCP_REG_END:   end_q   <= pwdata;
        RRCP_REG_EXT:   ext_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RRCP_REG_START: prdata = start_q;
      RRCP_REG_END:   prdata = end_q;
      RRCP_REG_EXT:   prdata = {16'd0, ext_q};
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // overlap test, used directly, and clipped span, registered before use
  assign overlap = (pos_q < end_q) && (sum_q > {1'b0, start_q});
  assign lo_calc = ((pos_q > start_q) ? pos_q : start_q) - start_q;
  assign hi_min  = (sum_q < {1'b0, end_q}) ? sum_q : {1'b0, end_q};
  assign hi_full = hi_min - {1'b0, start_q};

  // sequencer
  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    last_d        = last_q;
    clr_cmd_d     = clr_cmd_q;
    wb_valid_d    = 1'b0;
    wb_addr_d     = wb_addr_q;
    seen_d        = seen_q;
    stopped_d     = stopped_q;
    pos_d         = pos_q;
    idx_d         = idx_q;
    sum_d         = sum_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    res_count_d   = res_count_q;
    res_counted_d = res_counted_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    mem_ctl       = '0;
    mem_raddr     = ptr_q;
    mem_waddr     = wb_addr_q;
    mem_wdata     = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);

    // write-back of the bin read in the previous cycle
    if (wb_valid_q) begin
      mem_ctl.wr_en = 1'b1;
    end

    unique case (state_q)
      // zero sweep over the whole store
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = ptr_q;
        mem_wdata     = '0;
        ptr_d         = ptr_q + AW'(1);
        if (ptr_q == LastBin) begin
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pos_d         = in_item_i.read_position;
          idx_d         = in_item_i.bin_index;
          res_count_d   = '0;
          res_counted_d = 1'b0;
          unique case (in_item_i.command)
            RRCP_CMD_ADD:  state_d = S_SPAN;
            RRCP_CMD_READ: state_d = S_RDADDR;
            RRCP_CMD_CLEAR: begin
              seen_d    = 1'b0;
              stopped_d = 1'b0;
              clr_cmd_d = 1'b1;
              ptr_d     = '0;
              state_d   = S_CLEAR;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // read end position
      S_SPAN: begin
        sum_d   = {1'b0, pos_q} + 33'(ext_q);
        state_d = S_CHECK;
      end
      // overlap decision and stop rule
      S_CHECK: begin
        lo_d    = lo_calc;
        hi_d    = hi_full[31:0];
        state_d = S_DONE;
        if (!stopped_q && !(end_q < start_q)) begin
          if (overlap) begin
            seen_d        = 1'b1;
            res_counted_d = 1'b1;
            state_d       = S_CLIP;
          end else if (seen_q) begin
            stopped_d = 1'b1;
          end
        end
      end
      // clip span to the store
      S_CLIP: begin
        if (lo_q >= BinsW) begin
          state_d = S_DONE;
        end else begin
          ptr_d   = lo_q[AW-1:0];
          last_d  = (hi_q >= BinsW) ? LastBin : hi_q[AW-1:0];
          state_d = S_RUN;
        end
      end
      // read one bin per cycle, increment on the following cycle
      S_RUN: begin
        mem_ctl.rd_en = 1'b1;
        wb_valid_d    = 1'b1;
        wb_addr_d     = ptr_q;
        if (ptr_q == last_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      // single bin read
      S_RDADDR: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = AW'(idx_q);
        state_d       = S_RDDATA;
      end
      S_RDDATA: begin
        res_count_d = (32'(idx_q) < BinsW) ? 16'(mem_rdata) : '0;
        state_d     = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.bin_count    = res_count_q;
          out_d.read_counted = res_counted_q;
          out_d.list_stopped = stopped_q;
          clr_cmd_d          = 1'b0;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      last_q      <= '0;
      clr_cmd_q   <= 1'b0;
      wb_valid_q  <= 1'b0;
      seen_q      <= 1'b0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      last_q      <= last_d;
      clr_cmd_q   <= clr_cmd_d;
      wb_valid_q  <= wb_valid_d;
      seen_q      <= seen_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wb_addr_q     <= wb_addr_d;
    pos_q         <= pos_d;
    idx_q         <= idx_d;
    sum_q         <= sum_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    res_count_q   <= res_count_d;
    res_counted_q <= res_counted_d;
    out_q         <= out_d;
  end

  // bin memory
  rrcp_bin_store #(
    .Depth     (BINS),
    .Width     (COUNT_WIDTH),
    .AddrWidth (AW)
  ) u_bin_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // checks
`include "region_read_coverage_profile_top_assert.svh"

  `RRCP_ASSERT(a_wb_in_span, wb_valid_q |-> (wb_addr_q <= last_q), "write-back past span end")
  `RRCP_ASSERT(a_sweep_runs, (state_q == S_CLEAR && ptr_q != LastBin) |=> (state_q == S_CLEAR), "clear sweep cut short")
  `RRCP_ASSERT_NEVER(a_counted_live, out_valid_o && out_item_o.read_counted && out_item_o.list_stopped, "counted read on stopped list")
  `RRCP_ASSERT_NEVER(a_add_no_count, out_valid_o && out_item_o.read_counted && (out_item_o.bin_count != 16'd0), "add item with bin count")

endmodule
